### src/lhg_pkg.sv
// ----------------------------------------------------------------------------
// lhg_pkg
// Shared widths, constants and types of the leaped Halton point generator.
// ----------------------------------------------------------------------------
package lhg_pkg;

	localparam int NUM_BASES = 8;
	localparam int BASE_W    = 6;
	localparam int IDX_W     = $clog2(NUM_BASES);
	localparam int PT_W      = 24;
	localparam int COORD_W   = 32;
	localparam int LEAP      = 409;
	localparam int LEAP_W    = $clog2(LEAP + 1);
	// leaped index (p+1)*LEAP stays below 2^(PT_W+LEAP_W)
	localparam int N_W       = PT_W + LEAP_W;
	// b^k <= n*b, so the denominator fits in N_W+BASE_W bits
	localparam int DEN_W     = N_W + BASE_W;
	localparam int CNT_W     = $clog2((N_W > COORD_W) ? N_W : COORD_W);

	localparam logic [BASE_W-1:0] RESET_BASE [NUM_BASES] = '{
		6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
	};

	typedef enum logic [1:0] {
		LS_IDLE,
		LS_DIGIT,
		LS_FRAC,
		LS_DONE
	} lane_state_t;

	typedef struct packed {
		logic start;
		logic ack;
	} lane_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} lane_sts_t;

endpackage

### src/lhg_lane.sv
// ----------------------------------------------------------------------------
// lhg_lane
// One radical-inverse lane: bit-serial division by the base peels off the
// digits, the mirrored value and b^k accumulate, then a bit-serial restoring
// divider forms the Q0.32 fraction.
// ----------------------------------------------------------------------------
module lhg_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lhg_pkg::lane_ctl_t           ctl,
	input  logic [lhg_pkg::BASE_W-1:0]   base,
	input  logic [lhg_pkg::N_W-1:0]      index,
	output lhg_pkg::lane_sts_t           sts,
	output logic [lhg_pkg::COORD_W-1:0]  coord
);

	lhg_pkg::lane_state_t state_q, state_nxt;

	logic [lhg_pkg::N_W-1:0]              n_q;
	logic [lhg_pkg::BASE_W-1:0]           rem_q;
	logic [lhg_pkg::CNT_W-1:0]            cnt_q;
	logic [lhg_pkg::DEN_W-1:0]            mir_q;
	logic [lhg_pkg::DEN_W-1:0]            den_q;
	logic [lhg_pkg::DEN_W-1:0]            r_q;
	logic [lhg_pkg::COORD_W-1:0]          quo_q;

	logic [lhg_pkg::BASE_W:0]             trial;
	logic                                 dig_ge;
	logic [lhg_pkg::BASE_W:0]             trial_sub;
	logic [lhg_pkg::BASE_W-1:0]           dig_rem;
	logic [lhg_pkg::N_W-1:0]              quot;
	logic                                 quot_zero;
	logic                                 last_bit;
	logic [lhg_pkg::DEN_W+lhg_pkg::BASE_W-1:0] mir_prod;
	logic [lhg_pkg::DEN_W+lhg_pkg::BASE_W-1:0] den_prod;
	logic [lhg_pkg::DEN_W-1:0]            mir_next;
	logic [lhg_pkg::DEN_W:0]              r2;
	logic [lhg_pkg::DEN_W:0]              r2_sub;
	logic                                 fr_ge;
	logic                                 frac_last;
	logic                                 base_low;

	// digit step: shift one bit of n into the remainder
	assign trial     = {rem_q, n_q[lhg_pkg::N_W-1]};
	assign dig_ge    = trial >= {1'b0, base};
	assign trial_sub = trial - {1'b0, base};
	assign dig_rem   = dig_ge ? trial_sub[lhg_pkg::BASE_W-1:0] : trial[lhg_pkg::BASE_W-1:0];
	assign quot      = {n_q[lhg_pkg::N_W-2:0], dig_ge};
	assign quot_zero = (quot == '0);
	assign last_bit  = (cnt_q == lhg_pkg::CNT_W'(lhg_pkg::N_W - 1));
	assign mir_prod  = {lhg_pkg::BASE_W'(0), mir_q} * {lhg_pkg::DEN_W'(0), base};
	assign den_prod  = {lhg_pkg::BASE_W'(0), den_q} * {lhg_pkg::DEN_W'(0), base};
	assign mir_next  = mir_prod[lhg_pkg::DEN_W-1:0] + lhg_pkg::DEN_W'(dig_rem);

	// fraction step: restoring division, one quotient bit per cycle
	assign r2        = {r_q, 1'b0};
	assign r2_sub    = r2 - {1'b0, den_q};
	assign fr_ge     = r2 >= {1'b0, den_q};
	assign frac_last = (cnt_q == lhg_pkg::CNT_W'(lhg_pkg::COORD_W - 1));
	assign base_low  = (base < lhg_pkg::BASE_W'(2));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lhg_pkg::LS_IDLE: begin
				if (ctl.start) begin
					state_nxt = base_low ? lhg_pkg::LS_DONE : lhg_pkg::LS_DIGIT;
				end
			end
			lhg_pkg::LS_DIGIT: begin
				if (last_bit && quot_zero) begin
					state_nxt = lhg_pkg::LS_FRAC;
				end
			end
			lhg_pkg::LS_FRAC: begin
				if (frac_last) begin
					state_nxt = lhg_pkg::LS_DONE;
				end
			end
			lhg_pkg::LS_DONE: begin
				if (ctl.ack) begin
					state_nxt = lhg_pkg::LS_IDLE;
				end
			end
			default: state_nxt = lhg_pkg::LS_IDLE;
		endcase
	end

	always_comb begin
		sts.idle = (state_q == lhg_pkg::LS_IDLE);
		sts.done = (state_q == lhg_pkg::LS_DONE);
		coord    = quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lhg_pkg::LS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			lhg_pkg::LS_IDLE: begin
				if (ctl.start) begin
					n_q   <= index;
					rem_q <= '0;
					cnt_q <= '0;
					mir_q <= '0;
					den_q <= lhg_pkg::DEN_W'(1);
					quo_q <= '0;
				end
			end
			lhg_pkg::LS_DIGIT: begin
				n_q <= quot;
				if (last_bit) begin
					rem_q <= '0;
					cnt_q <= '0;
					mir_q <= mir_next;
					den_q <= den_prod[lhg_pkg::DEN_W-1:0];
					r_q   <= mir_next;
				end else begin
					rem_q <= dig_rem;
					cnt_q <= cnt_q + lhg_pkg::CNT_W'(1);
				end
			end
			lhg_pkg::LS_FRAC: begin
				r_q   <= fr_ge ? r2_sub[lhg_pkg::DEN_W-1:0] : r2[lhg_pkg::DEN_W-1:0];
				quo_q <= {quo_q[lhg_pkg::COORD_W-2:0], fr_ge};
				cnt_q <= cnt_q + lhg_pkg::CNT_W'(1);
			end
			lhg_pkg::LS_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

### src/leaped_halton_point_generator_top.sv
// ----------------------------------------------------------------------------
// leaped_halton_point_generator_top
// Leaped Halton point generator: radical inverse of (p+1)*LEAP in eight
// configurable bases, four x and four y Q0.32 coordinates per point.
//
//   channel  signals                        dir  width
//   in       in_valid/in_stall, point_number  in   24
//   out      out_valid/out_stall, coord_*     out  8 x 32
//   cfg      cfg_we, cfg_index, cfg_data      in   3 / 6
//
// The time per point grows with k, the digit count of the leaped index in the
// smallest configured base of two or more; a lane whose base is below two
// skips the digit and fraction steps and finishes with a zero coordinate.
// Each digit costs one pass of the bit-serial divide-by-base in the lanes.
// A new point is taken once the previous one has moved to the output
// register; a stalled output holds the lanes in their finished state.
// Reset restores the default bases and clears all control state.
// ----------------------------------------------------------------------------
module leaped_halton_point_generator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [lhg_pkg::PT_W-1:0]     point_number,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lhg_pkg::COORD_W-1:0]  coord_x0,
	output logic [lhg_pkg::COORD_W-1:0]  coord_x1,
	output logic [lhg_pkg::COORD_W-1:0]  coord_x2,
	output logic [lhg_pkg::COORD_W-1:0]  coord_x3,
	output logic [lhg_pkg::COORD_W-1:0]  coord_y0,
	output logic [lhg_pkg::COORD_W-1:0]  coord_y1,
	output logic [lhg_pkg::COORD_W-1:0]  coord_y2,
	output logic [lhg_pkg::COORD_W-1:0]  coord_y3,
	input  logic                         cfg_we,
	input  logic [lhg_pkg::IDX_W-1:0]    cfg_index,
	input  logic [lhg_pkg::BASE_W-1:0]   cfg_data
);

	logic [lhg_pkg::BASE_W-1:0]           base_q  [lhg_pkg::NUM_BASES];
	logic [lhg_pkg::COORD_W-1:0]          coord_q [lhg_pkg::NUM_BASES];
	logic [lhg_pkg::COORD_W-1:0]          lane_coord [lhg_pkg::NUM_BASES];
	lhg_pkg::lane_sts_t                   lane_sts [lhg_pkg::NUM_BASES];
	logic [lhg_pkg::NUM_BASES-1:0]        lane_done;
	logic [lhg_pkg::NUM_BASES-1:0]        lane_idle;
	lhg_pkg::lane_ctl_t                   lane_ctl;

	logic                                 busy_q;
	logic                                 out_valid_q;
	logic                                 in_xfer;
	logic                                 load_out;
	logic [lhg_pkg::PT_W:0]               pt_inc;
	logic [lhg_pkg::N_W-1:0]              n_idx;

	assign in_stall = busy_q;
	assign in_xfer  = in_valid && !busy_q;
	assign load_out = busy_q && (&lane_done) && (!out_valid_q || !out_stall);

	assign pt_inc = {1'b0, point_number} + (lhg_pkg::PT_W + 1)'(1);
	assign n_idx  = lhg_pkg::N_W'(pt_inc) * lhg_pkg::N_W'(lhg_pkg::LEAP);

	assign lane_ctl.start = in_xfer;
	assign lane_ctl.ack   = load_out;

	for (genvar g = 0; g < lhg_pkg::NUM_BASES; g++) begin : g_lane
		lhg_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl),
			.base   (base_q[g]),
			.index  (n_idx),
			.sts    (lane_sts[g]),
			.coord  (lane_coord[g])
		);
		assign lane_done[g] = lane_sts[g].done;
		assign lane_idle[g] = lane_sts[g].idle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lhg_pkg::NUM_BASES; i++) begin
				base_q[i] <= lhg_pkg::RESET_BASE[i];
			end
		end else if (cfg_we) begin
			base_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				busy_q <= 1'b1;
			end else if (load_out) begin
				busy_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			for (int i = 0; i < lhg_pkg::NUM_BASES; i++) begin
				coord_q[i] <= lane_coord[i];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign coord_x0  = coord_q[0];
	assign coord_x1  = coord_q[1];
	assign coord_x2  = coord_q[2];
	assign coord_x3  = coord_q[3];
	assign coord_y0  = coord_q[4];
	assign coord_y1  = coord_q[5];
	assign coord_y2  = coord_q[6];
	assign coord_y3  = coord_q[7];

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> busy_q && !(&lane_idle))
		else $error("lanes not started after input transfer");

	a_idle_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> &lane_idle)
		else $error("lane active while generator idle");

	a_load_out: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q && !busy_q)
		else $error("result not registered after lanes finished");

endmodule
